[rtl/bcvt_pkg.sv]
// ----------------------------------------------------------------------------
// bcvt_pkg
// Shared types and constants of the battery charge and voltage tracker.
// ----------------------------------------------------------------------------
package bcvt_pkg;

   localparam int ACC_W      = 58;
   localparam int MPLIER_W   = 16;
   localparam int DVD_W      = 57;
   localparam int DVS_W      = 36;
   localparam int QUO_W      = 33;
   localparam int QUO_NARROW = 15;

   localparam int LEVEL_W = 36;
   localparam int PCT_W   = 15;
   localparam int VOLT_W  = 21;

   localparam logic [LEVEL_W-1:0] FULL_NAH_RESET  = 36'd3750000000;
   localparam logic [LEVEL_W-1:0] NAH_PER_MAH     = 36'd1000000;
   localparam logic [PCT_W-1:0]   PCT_FULL        = 15'd25600;
   localparam logic [PCT_W-1:0]   LOW_SEG_TOP_Q8  = 15'd1792;
   localparam logic [DVD_W-1:0]   PCT_SCALE       = 57'd25600;
   localparam logic [39:0]        ENERGY_SCALE    = 40'd640000;

   localparam logic signed [ACC_W-1:0] P1_LOW  = -58'sd497091;
   localparam logic signed [ACC_W-1:0] P2_LOW  = 58'sd9679667;
   localparam logic signed [ACC_W-1:0] P3_LOW  = 58'sd197132288;
   localparam logic signed [ACC_W-1:0] P1_HIGH = 58'sd4460;
   localparam logic signed [ACC_W-1:0] P2_HIGH = 58'sd15761;
   localparam logic signed [ACC_W-1:0] P3_HIGH = 58'sd239927296;
   localparam logic signed [ACC_W-1:0] VOLT_ROUND = 58'sd8388608;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POLY_A,
      ST_POLY_B,
      ST_ENERGY,
      ST_DIVIDE,
      ST_UPDATE,
      ST_PCT_START,
      ST_PCT,
      ST_FINISH
   } state_type;

endpackage

[rtl/bcvt_mul.sv]
// ----------------------------------------------------------------------------
// bcvt_mul
// Bit-serial shift-and-add multiplier with a preset accumulator, one bit of
// the multiplier per cycle.
// ----------------------------------------------------------------------------
module bcvt_mul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [bcvt_pkg::ACC_W-1:0]      mcand_init,
   input  logic signed [bcvt_pkg::ACC_W-1:0]      acc_init,
   input  logic        [bcvt_pkg::MPLIER_W-1:0]   mplier_init,
   output logic                                   done,
   output logic signed [bcvt_pkg::ACC_W-1:0]      product
);

   logic signed [bcvt_pkg::ACC_W-1:0]    acc_ff;
   logic signed [bcvt_pkg::ACC_W-1:0]    mcand_ff;
   logic        [bcvt_pkg::MPLIER_W-1:0] mplier_ff;
   logic        [3:0]                    cnt_ff;
   logic                                 busy_ff;
   logic                                 done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'(bcvt_pkg::MPLIER_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= acc_init;
         mcand_ff  <= mcand_init;
         mplier_ff <= mplier_init;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[rtl/bcvt_div.sv]
// ----------------------------------------------------------------------------
// bcvt_div
// Restoring divider producing one quotient bit per cycle, for either a
// 33-bit or a 15-bit quotient that is known to fit.
// ----------------------------------------------------------------------------
module bcvt_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             wide,
   input  logic [bcvt_pkg::DVD_W-1:0]       dividend,
   input  logic [bcvt_pkg::DVS_W-1:0]       divisor,
   output logic                             done,
   output logic [bcvt_pkg::QUO_W-1:0]       quotient
);

   logic [bcvt_pkg::DVS_W-1:0] rem_ff;
   logic [bcvt_pkg::DVS_W-1:0] dvs_ff;
   logic [bcvt_pkg::QUO_W-1:0] low_ff;
   logic [bcvt_pkg::QUO_W-1:0] quo_ff;
   logic [5:0]                 cnt_ff;
   logic [5:0]                 limit_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [bcvt_pkg::DVS_W:0]   trial;
   logic [bcvt_pkg::DVS_W:0]   diff;
   logic                       qbit;

   assign trial = {rem_ff, low_ff[bcvt_pkg::QUO_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign qbit  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == limit_ff) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvs_ff <= divisor;
         quo_ff <= '0;
         if (wide) begin
            rem_ff   <= {12'd0, dividend[56:33]};
            low_ff   <= dividend[32:0];
            limit_ff <= 6'(bcvt_pkg::QUO_W - 1);
         end else begin
            rem_ff   <= dividend[50:15];
            low_ff   <= {dividend[14:0], 18'd0};
            limit_ff <= 6'(bcvt_pkg::QUO_NARROW - 1);
         end
      end else if (busy_ff) begin
         if (qbit) begin
            rem_ff <= diff[bcvt_pkg::DVS_W-1:0];
         end else begin
            rem_ff <= trial[bcvt_pkg::DVS_W-1:0];
         end
         low_ff <= low_ff << 1;
         quo_ff <= {quo_ff[bcvt_pkg::QUO_W-2:0], qbit};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/battery_charge_voltage_tracker.sv]
// ----------------------------------------------------------------------------
// battery_charge_voltage_tracker
// Coulomb-counting fuel gauge: voltage from a quadratic in the charge
// percent, drain from power and duration, level and percent updated.
//
//   Channel   Ports                               Transfer when
//   req       req_power_mw, req_duration_ms       req_valid and req_ready
//   rsp       rsp_* result fields                 rsp_valid and rsp_ready
//   csr       csr_max_capacity_mah                csr_wr_en
//
// A result takes three products of the serial multiplier and a 33-bit
// quotient of the serial divider, then a 15-bit quotient that is skipped
// when the capacity is zero. One item is in work at a time; the next
// request is taken once the result sits in the output register. Reset is
// synchronous and restores a full battery of 3750 mAh.
// ----------------------------------------------------------------------------
module battery_charge_voltage_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_power_mw,
   input  logic [19:0] req_duration_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_voltage_used_q8,
   output logic [32:0] rsp_consumed_nah,
   output logic [35:0] rsp_remaining_nah,
   output logic [14:0] rsp_charge_pct_q8,
   output logic        rsp_empty_res,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_max_capacity_mah
);

   bcvt_pkg::state_type state_ff;
   bcvt_pkg::state_type state_in;

   logic [bcvt_pkg::LEVEL_W-1:0] den_ff;
   logic [bcvt_pkg::LEVEL_W-1:0] level_ff;
   logic [bcvt_pkg::PCT_W-1:0]   pct_ff;
   logic [15:0]                  power_ff;
   logic [19:0]                  duration_ff;
   logic [bcvt_pkg::VOLT_W-1:0]  volt_ff;
   logic [32:0]                  used_ff;
   logic                         empty_ff;
   logic                         rsp_valid_ff;

   logic                                   mul_start;
   logic signed [bcvt_pkg::ACC_W-1:0]      mul_mcand;
   logic signed [bcvt_pkg::ACC_W-1:0]      mul_acc;
   logic        [bcvt_pkg::MPLIER_W-1:0]   mul_mplier;
   logic                                   mul_done;
   logic signed [bcvt_pkg::ACC_W-1:0]      mul_product;

   logic                                   div_start;
   logic                                   div_wide;
   logic [bcvt_pkg::DVD_W-1:0]             div_dividend;
   logic [bcvt_pkg::DVS_W-1:0]             div_divisor;
   logic                                   div_done;
   logic [bcvt_pkg::QUO_W-1:0]             div_quotient;

   logic                                   volt_load;
   logic                                   used_load;
   logic                                   level_load;
   logic                                   pct_load;
   logic                                   rsp_load;

   logic                                   seg_low;
   logic signed [bcvt_pkg::ACC_W-1:0]      volt_sum;
   logic [23:0]                            nine_volt;
   logic [39:0]                            energy_mcand;
   logic [bcvt_pkg::LEVEL_W-1:0]           used_ext;
   logic [bcvt_pkg::LEVEL_W-1:0]           cfg_den;

   assign seg_low      = (pct_ff <= bcvt_pkg::LOW_SEG_TOP_Q8);
   assign volt_sum     = mul_product + bcvt_pkg::VOLT_ROUND;
   assign nine_volt    = {volt_ff, 3'b000} + 24'(volt_ff);
   assign energy_mcand = 40'(duration_ff) * bcvt_pkg::ENERGY_SCALE;
   assign used_ext     = {3'd0, used_ff};
   assign cfg_den      = 36'(csr_max_capacity_mah) * bcvt_pkg::NAH_PER_MAH;

   bcvt_mul u_mul (
      .clock       (clock),
      .reset       (reset),
      .start       (mul_start),
      .mcand_init  (mul_mcand),
      .acc_init    (mul_acc),
      .mplier_init (mul_mplier),
      .done        (mul_done),
      .product     (mul_product)
   );

   bcvt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .wide     (div_wide),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bcvt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bcvt_pkg::ST_POLY_A;
            end
         end
         bcvt_pkg::ST_POLY_A: begin
            if (mul_done) begin
               state_in = bcvt_pkg::ST_POLY_B;
            end
         end
         bcvt_pkg::ST_POLY_B: begin
            if (mul_done) begin
               state_in = bcvt_pkg::ST_ENERGY;
            end
         end
         bcvt_pkg::ST_ENERGY: begin
            if (mul_done) begin
               state_in = bcvt_pkg::ST_DIVIDE;
            end
         end
         bcvt_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = bcvt_pkg::ST_UPDATE;
            end
         end
         bcvt_pkg::ST_UPDATE: begin
            state_in = bcvt_pkg::ST_PCT_START;
         end
         bcvt_pkg::ST_PCT_START: begin
            if (den_ff == '0) begin
               state_in = bcvt_pkg::ST_FINISH;
            end else begin
               state_in = bcvt_pkg::ST_PCT;
            end
         end
         bcvt_pkg::ST_PCT: begin
            if (div_done) begin
               state_in = bcvt_pkg::ST_FINISH;
            end
         end
         bcvt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = bcvt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcvt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      mul_start    = 1'b0;
      mul_mcand    = seg_low ? bcvt_pkg::P1_LOW : bcvt_pkg::P1_HIGH;
      mul_acc      = (seg_low ? bcvt_pkg::P2_LOW : bcvt_pkg::P2_HIGH) <<< 8;
      mul_mplier   = {1'b0, pct_ff};
      div_start    = 1'b0;
      div_wide     = 1'b1;
      div_dividend = mul_product[bcvt_pkg::DVD_W-1:0];
      div_divisor  = {12'd0, nine_volt};
      volt_load    = 1'b0;
      used_load    = 1'b0;
      level_load   = 1'b0;
      pct_load     = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         bcvt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            mul_start = req_valid;
         end
         bcvt_pkg::ST_POLY_A: begin
            mul_start = mul_done;
            mul_mcand = mul_product;
            mul_acc   = (seg_low ? bcvt_pkg::P3_LOW : bcvt_pkg::P3_HIGH) <<< 16;
         end
         bcvt_pkg::ST_POLY_B: begin
            mul_start  = mul_done;
            mul_mcand  = $signed({18'd0, energy_mcand});
            mul_acc    = '0;
            mul_mplier = power_ff;
            volt_load  = mul_done;
         end
         bcvt_pkg::ST_ENERGY: begin
            div_start = mul_done;
         end
         bcvt_pkg::ST_DIVIDE: begin
            used_load = div_done;
         end
         bcvt_pkg::ST_UPDATE: begin
            level_load = 1'b1;
         end
         bcvt_pkg::ST_PCT_START: begin
            div_start    = (den_ff != '0);
            div_wide     = 1'b0;
            div_dividend = 57'(level_ff) * bcvt_pkg::PCT_SCALE;
            div_divisor  = den_ff;
         end
         bcvt_pkg::ST_PCT: begin
            pct_load = div_done;
         end
         bcvt_pkg::ST_FINISH: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcvt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         den_ff       <= bcvt_pkg::FULL_NAH_RESET;
         level_ff     <= bcvt_pkg::FULL_NAH_RESET;
         pct_ff       <= bcvt_pkg::PCT_FULL;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            den_ff   <= cfg_den;
            level_ff <= cfg_den;
            pct_ff   <= (csr_max_capacity_mah != 16'd0) ? bcvt_pkg::PCT_FULL : '0;
         end else begin
            if (level_load) begin
               if (used_ext >= level_ff) begin
                  level_ff <= '0;
               end else begin
                  level_ff <= level_ff - used_ext;
               end
            end
            if (pct_load) begin
               pct_ff <= div_quotient[bcvt_pkg::PCT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         power_ff    <= req_power_mw;
         duration_ff <= req_duration_ms;
      end
      if (volt_load) begin
         volt_ff <= volt_sum[44:24];
      end
      if (used_load) begin
         used_ff <= div_quotient;
      end
      if (level_load) begin
         empty_ff <= (used_ext >= level_ff);
      end
      if (rsp_load) begin
         rsp_voltage_used_q8 <= volt_ff;
         rsp_consumed_nah    <= used_ff;
         rsp_remaining_nah   <= level_ff;
         rsp_charge_pct_q8   <= pct_ff;
         rsp_empty_res       <= empty_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
